@@ sv/ttsn_pkg.sv @@
// ============================================================================
// ttsn_pkg
// Shared types, register codes and constant tables for the touch-to-note mapper.
// ============================================================================
package ttsn_pkg;

    localparam int TABLE_ENTRIES = 16;
    localparam int ENTRY_W       = 16;
    localparam int WORD_W        = 64;
    localparam int CFG_IDX_W     = 4;
    localparam int IX_MAX_W      = 12;   // widest integer column part (12.4 at 4 fraction bits)
    localparam int FX_MAX_W      = 12;   // widest column fraction
    localparam int RECIP_SHIFT   = 16;
    localparam int RECIP_W       = 17;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_LOW    = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_SECOND = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_THIRD  = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_HIGH   = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_LENGTH = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TONIC        = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_OFFSET   = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_COLUMN_OFFSET = 4'd7;

    // reset scale: chromatic 0..12
    localparam logic [WORD_W-1:0] SCALE_LOW_RESET    = 64'h0300_0200_0100_0000;
    localparam logic [WORD_W-1:0] SCALE_SECOND_RESET = 64'h0700_0600_0500_0400;
    localparam logic [WORD_W-1:0] SCALE_THIRD_RESET  = 64'h0B00_0A00_0900_0800;
    localparam logic [WORD_W-1:0] SCALE_HIGH_RESET   = 64'h0000_0000_0000_0C00;
    localparam logic [4:0]        SCALE_LENGTH_RESET = 5'd13;

    // floor(2^16 / d); entry 0 is never used on a valid scale
    localparam logic [RECIP_W-1:0] RECIP_TABLE [TABLE_ENTRIES] = '{
        17'd0,     17'd65536, 17'd32768, 17'd21845,
        17'd16384, 17'd13107, 17'd10922, 17'd9362,
        17'd8192,  17'd7281,  17'd6553,  17'd5957,
        17'd5461,  17'd5041,  17'd4681,  17'd4369
    };

    typedef struct packed {
        logic [15:0] column_pos;
        logic [15:0] row_pos;
    } touch_t;

    typedef struct packed {
        logic signed [31:0] note_value;
        logic [15:0]        column_echo;
        logic [15:0]        row_echo;
        logic               bad_scale;
        logic               saturated;
    } note_t;

    typedef struct packed {
        logic [TABLE_ENTRIES*ENTRY_W-1:0] scale;
        logic [4:0]                       length;
        logic signed [15:0]               tonic;
        logic signed [15:0]               row_offset;
        logic signed [15:0]               column_offset;
    } cfg_t;

    // terms handed from the index pipeline to the accumulate pipeline
    typedef struct packed {
        touch_t              touch;
        logic                bad;
        logic [IX_MAX_W-1:0] wraps;
        logic [FX_MAX_W-1:0] frac;
        logic [ENTRY_W-1:0]  e0;
        logic [ENTRY_W-1:0]  e1;
        logic [ENTRY_W-1:0]  span;
        logic signed [16:0]  base;
        logic signed [32:0]  row_term;
    } term_t;

    function automatic logic [ENTRY_W-1:0] get_entry(
        input logic [TABLE_ENTRIES*ENTRY_W-1:0] tbl,
        input logic [3:0]                       k
    );
        return tbl[{k, 4'b0000} +: ENTRY_W];
    endfunction

endpackage

@@ sv/ttsn_skid.sv @@
// ============================================================================
// ttsn_skid
// Input skid stage: registered ready, one spare slot for a stalled transfer.
// ============================================================================
module ttsn_skid (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  ttsn_pkg::touch_t s_touch,
    input  logic             en,
    output logic             head_valid,
    output ttsn_pkg::touch_t head_touch
);
    import ttsn_pkg::*;

    logic   skid_valid_reg;
    touch_t skid_touch_reg;

    assign s_ready    = !skid_valid_reg;
    assign head_valid = skid_valid_reg || s_valid;
    assign head_touch = skid_valid_reg ? skid_touch_reg : s_touch;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg && en) begin
            skid_valid_reg <= 1'b0;
        end else if (!skid_valid_reg && s_valid && !en) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!skid_valid_reg && s_valid && !en) begin
            skid_touch_reg <= s_touch;
        end
    end

endmodule

@@ sv/ttsn_index.sv @@
// ============================================================================
// ttsn_index
// Stages A-D: scale length check, column index divide by reciprocal,
// remainder correction and scale table reads.
// ============================================================================
module ttsn_index #(
    parameter int MAX_SCALE_ENTRIES = 16,
    parameter int FRACTION_BITS     = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  ttsn_pkg::cfg_t   cfg,
    input  logic             in_valid,
    input  ttsn_pkg::touch_t in_touch,
    output logic             out_valid,
    output ttsn_pkg::term_t  out_term
);
    import ttsn_pkg::*;

    localparam int IXW  = 16 - FRACTION_BITS;
    localparam int LENW = $clog2(MAX_SCALE_ENTRIES + 1);
    localparam int SZW  = $clog2(MAX_SCALE_ENTRIES);

    // ---- stage A: clamp length, split column, row product
    logic [LENW-1:0]    len_eff;
    logic signed [32:0] row_term;

    assign len_eff  = (cfg.length > 5'(MAX_SCALE_ENTRIES)) ? LENW'(MAX_SCALE_ENTRIES)
                                                           : cfg.length[LENW-1:0];
    assign row_term = 33'($signed({1'b0, in_touch.row_pos})) * 33'(cfg.row_offset);

    logic               a_valid_reg;
    touch_t             a_touch_reg;
    logic               a_bad_reg;
    logic [SZW-1:0]     a_sz_reg;
    logic [IXW-1:0]     a_ix_reg;
    logic [RECIP_W-1:0] a_recip_reg;
    logic signed [32:0] a_row_reg;
    logic [LENW-1:0]    sz_full;

    assign sz_full = len_eff - LENW'(1);

    // ---- stage B: q0 = ix * floor(2^16/sz) >> 16, low by at most one
    logic [IXW+RECIP_W-1:0] prod;
    assign prod = (IXW+RECIP_W)'(a_ix_reg) * (IXW+RECIP_W)'(a_recip_reg);

    logic               b_valid_reg;
    touch_t             b_touch_reg;
    logic               b_bad_reg;
    logic [SZW-1:0]     b_sz_reg;
    logic [IXW-1:0]     b_ix_reg;
    logic [IXW-1:0]     b_q0_reg;
    logic signed [32:0] b_row_reg;

    // ---- stage C: trial remainder, below 2*sz
    logic [IXW+SZW-1:0] qs;
    logic [IXW+SZW-1:0] r_full;
    assign qs     = (IXW+SZW)'(b_q0_reg) * (IXW+SZW)'(b_sz_reg);
    assign r_full = (IXW+SZW)'(b_ix_reg) - qs;

    logic               c_valid_reg;
    touch_t             c_touch_reg;
    logic               c_bad_reg;
    logic [SZW-1:0]     c_sz_reg;
    logic [SZW:0]       c_r0_reg;
    logic [IXW-1:0]     c_q0_reg;
    logic signed [32:0] c_row_reg;

    // ---- stage D: correct, read table
    logic           ge;
    logic [SZW-1:0] n;
    logic [IXW-1:0] wraps;
    logic [3:0]     k0;
    term_t          d_next;

    assign ge    = c_r0_reg >= {1'b0, c_sz_reg};
    assign n     = ge ? SZW'(c_r0_reg - {1'b0, c_sz_reg}) : c_r0_reg[SZW-1:0];
    assign wraps = c_q0_reg + IXW'(ge);
    assign k0    = 4'(n);

    always_comb begin
        d_next.touch    = c_touch_reg;
        d_next.bad      = c_bad_reg;
        d_next.wraps    = IX_MAX_W'(wraps);
        d_next.frac     = FX_MAX_W'(c_touch_reg.column_pos[FRACTION_BITS-1:0]);
        d_next.e0       = get_entry(cfg.scale, k0);
        d_next.e1       = get_entry(cfg.scale, k0 + 4'd1);
        d_next.span     = get_entry(cfg.scale, 4'(c_sz_reg));
        d_next.base     = 17'(cfg.tonic) + 17'(cfg.column_offset);
        d_next.row_term = c_row_reg;
    end

    logic  d_valid_reg;
    term_t d_reg;

    assign out_valid = d_valid_reg;
    assign out_term  = d_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
        end else if (en) begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
            d_valid_reg <= c_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_touch_reg <= in_touch;
            a_bad_reg   <= len_eff < LENW'(2);
            a_sz_reg    <= SZW'(sz_full);
            a_ix_reg    <= in_touch.column_pos[15:FRACTION_BITS];
            a_recip_reg <= RECIP_TABLE[4'(SZW'(sz_full))];
            a_row_reg   <= row_term;

            b_touch_reg <= a_touch_reg;
            b_bad_reg   <= a_bad_reg;
            b_sz_reg    <= a_sz_reg;
            b_ix_reg    <= a_ix_reg;
            b_q0_reg    <= prod[RECIP_SHIFT +: IXW];
            b_row_reg   <= a_row_reg;

            c_touch_reg <= b_touch_reg;
            c_bad_reg   <= b_bad_reg;
            c_sz_reg    <= b_sz_reg;
            c_r0_reg    <= r_full[SZW:0];
            c_q0_reg    <= b_q0_reg;
            c_row_reg   <= b_row_reg;

            d_reg       <= d_next;
        end
    end

endmodule

@@ sv/ttsn_accum.sv @@
// ============================================================================
// ttsn_accum
// Stages E-H: octave and interpolation products, exact sum, rounding and
// saturation into the output register.
// ============================================================================
module ttsn_accum #(
    parameter int FRACTION_BITS = 8
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            en,
    input  logic            in_valid,
    input  ttsn_pkg::term_t in_term,
    output logic            out_valid,
    output ttsn_pkg::note_t out_note
);
    import ttsn_pkg::*;

    localparam int ACCW = 48;
    localparam logic signed [ACCW-1:0] HALF    = ACCW'(1) << (FRACTION_BITS - 1);
    localparam logic signed [ACCW-1:0] NOTE_MAX = ACCW'(32'h7FFF_FFFF);
    localparam logic signed [ACCW-1:0] NOTE_MIN = -(ACCW'(64'h8000_0000));

    // ---- stage E: wraps * span, neighbor difference, base + e0
    logic [IX_MAX_W+ENTRY_W-1:0] ws;
    logic signed [16:0]          diff;
    logic signed [17:0]          coarse;
    logic signed [17:0]          base_ext;

    assign ws       = (IX_MAX_W+ENTRY_W)'(in_term.wraps) * (IX_MAX_W+ENTRY_W)'(in_term.span);
    assign diff     = $signed({1'b0, in_term.e1}) - $signed({1'b0, in_term.e0});
    assign base_ext = 18'(in_term.base);
    assign coarse   = base_ext + $signed({2'b00, in_term.e0});

    logic                        e_valid_reg;
    touch_t                      e_touch_reg;
    logic                        e_bad_reg;
    logic [IX_MAX_W+ENTRY_W-1:0] e_ws_reg;
    logic signed [16:0]          e_diff_reg;
    logic signed [17:0]          e_coarse_reg;
    logic [FX_MAX_W-1:0]         e_frac_reg;
    logic signed [32:0]          e_row_reg;

    // ---- stage F: interpolation product, coarse note
    logic signed [FX_MAX_W+17:0] dfx;
    logic signed [31:0]          coarse_ext;
    logic signed [31:0]          ws_ext;

    assign dfx        = (FX_MAX_W+18)'(e_diff_reg)
                      * (FX_MAX_W+18)'($signed({1'b0, e_frac_reg}));
    assign coarse_ext = 32'(e_coarse_reg);
    assign ws_ext     = $signed(32'(e_ws_reg));

    logic                        f_valid_reg;
    touch_t                      f_touch_reg;
    logic                        f_bad_reg;
    logic signed [31:0]          f_coarse_reg;
    logic signed [FX_MAX_W+17:0] f_dfx_reg;
    logic signed [32:0]          f_row_reg;

    // ---- stage G: exact sum plus half LSB
    logic signed [ACCW-1:0] c_term;
    logic signed [ACCW-1:0] d_term;
    logic signed [ACCW-1:0] r_term;

    assign c_term = ACCW'(f_coarse_reg);
    assign d_term = ACCW'(f_dfx_reg);
    assign r_term = ACCW'(f_row_reg);

    logic                   g_valid_reg;
    touch_t                 g_touch_reg;
    logic                   g_bad_reg;
    logic signed [ACCW-1:0] g_acc_reg;

    // ---- stage H: floor shift, clip
    logic signed [ACCW-1:0] shifted;
    note_t                  h_next;

    assign shifted = g_acc_reg >>> FRACTION_BITS;

    always_comb begin
        h_next.column_echo = g_touch_reg.column_pos;
        h_next.row_echo    = g_touch_reg.row_pos;
        h_next.bad_scale   = g_bad_reg;
        h_next.saturated   = 1'b0;
        h_next.note_value  = 32'(shifted);
        if (g_bad_reg) begin
            h_next.note_value = '0;
        end else if (shifted > NOTE_MAX) begin
            h_next.note_value = 32'sh7FFF_FFFF;
            h_next.saturated  = 1'b1;
        end else if (shifted < NOTE_MIN) begin
            h_next.note_value = 32'sh8000_0000;
            h_next.saturated  = 1'b1;
        end
    end

    logic  h_valid_reg;
    note_t h_reg;

    assign out_valid = h_valid_reg;
    assign out_note  = h_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            e_valid_reg <= 1'b0;
            f_valid_reg <= 1'b0;
            g_valid_reg <= 1'b0;
            h_valid_reg <= 1'b0;
        end else if (en) begin
            e_valid_reg <= in_valid;
            f_valid_reg <= e_valid_reg;
            g_valid_reg <= f_valid_reg;
            h_valid_reg <= g_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            e_touch_reg  <= in_term.touch;
            e_bad_reg    <= in_term.bad;
            e_ws_reg     <= ws;
            e_diff_reg   <= diff;
            e_coarse_reg <= coarse;
            e_frac_reg   <= in_term.frac;
            e_row_reg    <= in_term.row_term;

            f_touch_reg  <= e_touch_reg;
            f_bad_reg    <= e_bad_reg;
            f_coarse_reg <= coarse_ext + ws_ext;
            f_dfx_reg    <= dfx;
            f_row_reg    <= e_row_reg;

            g_touch_reg  <= f_touch_reg;
            g_bad_reg    <= f_bad_reg;
            g_acc_reg    <= (c_term <<< FRACTION_BITS) + d_term + r_term + HALF;

            h_reg        <= h_next;
        end
    end

endmodule

@@ sv/touch_to_scale_note_mapper.sv @@
// ============================================================================
// touch_to_scale_note_mapper
// Maps a touch (column, row in unsigned fixed point) to a saturated signed
// pitch through a configurable scale table with octave wrap.
// ============================================================================
// Throughput: one touch per cycle while the output side does not stall;
//   eight register stages, A to H, the last of them the output register,
//   and an input skid slot let the sides run without bubbles.
// Reset: synchronous, active low; empties the pipeline and the skid slot and
//   loads the chromatic 13-entry scale with zero tonic and offsets.
// ============================================================================
module touch_to_scale_note_mapper #(
    parameter int MAX_SCALE_ENTRIES = 16,
    parameter int FRACTION_BITS     = 8
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // configuration write port
    input  logic                               cfg_wr_en,
    input  logic [ttsn_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ttsn_pkg::WORD_W-1:0]        cfg_wdata,
    // touch input
    input  logic                               s_valid,
    output logic                               s_ready,
    input  ttsn_pkg::touch_t                   s_touch,
    // note output
    output logic                               m_valid,
    input  logic                               m_ready,
    output ttsn_pkg::note_t                    m_note
);
    import ttsn_pkg::*;

    // ------------------------------------------------------------------
    // Configuration registers. Write them only while the pipeline is empty
    // (the block does not enforce it); every stage reads them live.
    // ------------------------------------------------------------------
    logic [WORD_W-1:0]  scale_low_reg;
    logic [WORD_W-1:0]  scale_second_reg;
    logic [WORD_W-1:0]  scale_third_reg;
    logic [WORD_W-1:0]  scale_high_reg;
    logic [4:0]         scale_length_reg;
    logic signed [15:0] tonic_reg;
    logic signed [15:0] row_offset_reg;
    logic signed [15:0] column_offset_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scale_low_reg     <= SCALE_LOW_RESET;
            scale_second_reg  <= SCALE_SECOND_RESET;
            scale_third_reg   <= SCALE_THIRD_RESET;
            scale_high_reg    <= SCALE_HIGH_RESET;
            scale_length_reg  <= SCALE_LENGTH_RESET;
            tonic_reg         <= '0;
            row_offset_reg    <= '0;
            column_offset_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_SCALE_LOW:     scale_low_reg     <= cfg_wdata;
                REG_SCALE_SECOND:  scale_second_reg  <= cfg_wdata;
                REG_SCALE_THIRD:   scale_third_reg   <= cfg_wdata;
                REG_SCALE_HIGH:    scale_high_reg    <= cfg_wdata;
                REG_SCALE_LENGTH:  scale_length_reg  <= cfg_wdata[4:0];
                REG_TONIC:         tonic_reg         <= cfg_wdata[15:0];
                REG_ROW_OFFSET:    row_offset_reg    <= cfg_wdata[15:0];
                REG_COLUMN_OFFSET: column_offset_reg <= cfg_wdata[15:0];
                default: begin
                    // unmapped index: write dropped
                end
            endcase
        end
    end

    cfg_t cfg;
    always_comb begin
        cfg.scale         = {scale_high_reg, scale_third_reg, scale_second_reg, scale_low_reg};
        cfg.length        = scale_length_reg;
        cfg.tonic         = tonic_reg;
        cfg.row_offset    = row_offset_reg;
        cfg.column_offset = column_offset_reg;
    end

    // ------------------------------------------------------------------
    // Pipeline advance: every stage moves unless the output register holds
    // a result the sink has not taken. Bubbles travel as cleared valids.
    // ------------------------------------------------------------------
    logic en;
    assign en = !m_valid || m_ready;

    // Input skid slot keeps s_ready registered, off the m_ready path.
    logic   head_valid;
    touch_t head_touch;

    ttsn_skid u_skid (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_touch    (s_touch),
        .en         (en),
        .head_valid (head_valid),
        .head_touch (head_touch)
    );

    // Stages A-D: length clamp, divide by (length-1) via reciprocal,
    // remainder fix-up, table reads.
    logic  term_valid;
    term_t term;

    ttsn_index #(
        .MAX_SCALE_ENTRIES (MAX_SCALE_ENTRIES),
        .FRACTION_BITS     (FRACTION_BITS)
    ) u_index (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .cfg       (cfg),
        .in_valid  (head_valid),
        .in_touch  (head_touch),
        .out_valid (term_valid),
        .out_term  (term)
    );

    // Stages E-H: products, exact sum, round half up, clip. Stage H is the
    // output register.
    ttsn_accum #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_accum (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (term_valid),
        .in_term   (term),
        .out_valid (m_valid),
        .out_note  (m_note)
    );

endmodule

@@ sv/ttsn_checker.sv @@
// ============================================================================
// ttsn_checker
// Port-level checks for the touch-to-note mapper, bound to the top level.
// ============================================================================
module ttsn_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_valid,
    input logic                           s_ready,
    input logic                           m_valid,
    input logic                           m_ready,
    input ttsn_pkg::note_t                m_note
);
    import ttsn_pkg::*;

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_note))
        else $error("output changed while stalled");

    // reset empties the pipeline and opens the input
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("pipeline not empty after reset");

    // a transfer taken while the output stalls fills the skid slot
    a_skid_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && m_valid && !m_ready |=> !s_ready)
        else $error("input still open with skid slot in use");

    // bad scale forces a zero, unclipped note
    a_bad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_note.bad_scale |-> m_note.note_value == 32'sd0 && !m_note.saturated)
        else $error("bad scale result not zero");

    // a clipped note sits at a range limit
    a_sat_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_note.saturated |->
            (m_note.note_value == 32'sh7FFF_FFFF || m_note.note_value == 32'sh8000_0000))
        else $error("saturated note not at a limit");

endmodule

bind touch_to_scale_note_mapper ttsn_checker u_ttsn_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_note  (m_note)
);
